>>> src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the convex polygon point test core.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // coordinate format: signed Q16.8
    localparam int COORD_W   = 24;
    localparam int MAX_VERT  = 64;
    localparam int ADDR_W    = $clog2(MAX_VERT);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;

    // stream payload widths
    localparam int IN_FIELDS_W = ADDR_W + 2 * COORD_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // opcodes carried in tuser
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    // control that travels with one edge down the cross-product pipe
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_edge_ctl;

endpackage

>>> src/cpt_cross.sv
// ----------------------------------------------------------------------------
// cpt_cross
// Two-stage edge unit: forms both partial cross products of one edge with
// (point - edge start), then registers whether their difference is negative.
// ----------------------------------------------------------------------------
module cpt_cross (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpt_pkg::t_edge_ctl  i_ctl,
    input  cpt_pkg::t_vertex    i_start,
    input  cpt_pkg::t_vertex    i_end,
    input  cpt_pkg::t_vertex    i_point,
    output cpt_pkg::t_edge_ctl  o_ctl,
    output logic                o_neg
);
    import cpt_pkg::*;

    logic signed [DIFF_W-1:0] d1x, d1y, d2x, d2y;
    logic signed [PROD_W-1:0] p1, p2;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    t_edge_ctl                r_ctl_a;
    t_edge_ctl                r_ctl_b;
    logic                     r_neg;

    // edge vector and point offset, sign extended by one bit
    assign d1x = DIFF_W'(i_end.x)   - DIFF_W'(i_start.x);
    assign d1y = DIFF_W'(i_end.y)   - DIFF_W'(i_start.y);
    assign d2x = DIFF_W'(i_point.x) - DIFF_W'(i_start.x);
    assign d2y = DIFF_W'(i_point.y) - DIFF_W'(i_start.y);

    // exact products, 25 x 25 -> 50 bits
    assign p1 = PROD_W'(d1x) * PROD_W'(d2y);
    assign p2 = PROD_W'(d1y) * PROD_W'(d2x);

    // stage A: products
    always_ff @(posedge i_clk) begin
        r_p1 <= p1;
        r_p2 <= p2;
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else begin
            r_ctl_a <= i_ctl;
        end
    end

    // stage B: sign of cross product (zero counts as non-negative)
    always_ff @(posedge i_clk) begin
        r_neg <= (r_p1 < r_p2);
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else begin
            r_ctl_b <= r_ctl_a;
        end
    end

    assign o_ctl = r_ctl_b;
    assign o_neg = r_neg;

endmodule

>>> src/convex_polygon_point_test_core.sv
// ----------------------------------------------------------------------------
// convex_polygon_point_test_core
// Vertex table in one synchronous memory; a query walks the table one vertex
// per cycle and checks that every edge cross product has the first sign.
// ----------------------------------------------------------------------------
// Flow: a vertex write gives no result. No new beat is accepted while a query
//   is in progress, as the walk of the table holds the single memory read port,
//   so one query gives its result before the next is taken; vertex writes are
//   taken back to back while idle.
// Reset: synchronous active low; clears vertex_count and control state. The
//   vertex table is not cleared and holds garbage until written.
module convex_polygon_point_test_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: vertex_count
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpt_pkg::CNT_W-1:0]         i_cfg_data,
    // input beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] vertex_index, [29:6] coord_x, [53:30] coord_y, [55:54] zero
    input  logic [cpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] opcode
    input  logic                              s_axis_tuser,
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] inside_res, [7:1] zero
    output logic [cpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import cpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_addr;
    t_vertex           r_pt;

    // vertex table
    t_vertex           mem [MAX_VERT];
    t_vertex           r_mem_q;

    // walk stage registers
    logic              r_s1_vld;
    logic [CNT_W-1:0]  r_s1_addr;
    t_vertex           r_first;
    t_vertex           r_prev;

    logic              r_first_neg;
    logic              r_inside;
    logic              r_out_vld;
    logic              r_out_res;

    logic              in_acc;
    logic [ADDR_W-1:0] in_idx;
    t_vertex           in_vtx;
    logic [CNT_W-1:0]  cfg_sat;
    t_vertex           end_vtx;
    t_edge_ctl         edge_ctl;
    t_edge_ctl         res_ctl;
    logic              res_neg;
    logic              out_free;

    // input unpacking
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_idx   = s_axis_tdata[ADDR_W-1:0];
    assign in_vtx.x = s_axis_tdata[ADDR_W+COORD_W-1:ADDR_W];
    assign in_vtx.y = s_axis_tdata[ADDR_W+2*COORD_W-1:ADDR_W+COORD_W];

    // vertex_count saturates at the table depth
    assign cfg_sat = (i_cfg_data > CNT_W'(MAX_VERT)) ? CNT_W'(MAX_VERT) : i_cfg_data;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_vld || m_axis_tready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= cfg_sat;
        end
    end

    // table memory: written by vertex beats, read by the query walk
    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == OP_VERTEX)) begin
            mem[in_idx] <= in_vtx;
        end
        r_mem_q <= mem[r_addr[ADDR_W-1:0]];
    end

    // edge end: table vertex, or vertex 0 again for the closing edge
    assign end_vtx = (r_s1_addr == r_n) ? r_first : r_mem_q;

    always_comb begin
        edge_ctl.vld   = r_s1_vld && (r_s1_addr != '0);
        edge_ctl.first = (r_s1_addr == CNT_W'(1));
        edge_ctl.last  = (r_s1_addr == r_n);
    end

    // previous and first vertex along the walk
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prev <= end_vtx;
            if (r_s1_addr == '0) begin
                r_first <= r_mem_q;
            end
        end
    end

    cpt_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (edge_ctl),
        .i_start (r_prev),
        .i_end   (end_vtx),
        .i_point (r_pt),
        .o_ctl   (res_ctl),
        .o_neg   (res_neg)
    );

    // control sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_n         <= '0;
            r_s1_vld    <= 1'b0;
            r_s1_addr   <= '0;
            r_first_neg <= 1'b0;
            r_inside    <= 1'b1;
            r_out_vld   <= 1'b0;
            r_out_res   <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            r_s1_vld <= 1'b0;

            // sign class check per finished edge
            if (res_ctl.vld) begin
                if (res_ctl.first) begin
                    r_first_neg <= res_neg;
                end else if (res_neg != r_first_neg) begin
                    r_inside <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (s_axis_tuser == OP_QUERY)) begin
                        r_pt     <= in_vtx;
                        r_n      <= r_count;
                        r_addr   <= '0;
                        r_inside <= 1'b1;
                        r_state  <= (r_count == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    // one table read per cycle, plus the closing step
                    r_s1_vld  <= 1'b1;
                    r_s1_addr <= r_addr;
                    r_addr    <= r_addr + CNT_W'(1);
                    if (r_addr == r_n) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (res_ctl.vld && res_ctl.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_res <= r_inside;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_out_res};

endmodule
